>>> sv/pmat_pkg.sv
// ----------------------------------------------------------------------------
// pmat_pkg
// Shared sizes and widths for the paged memory allocator and translator.
// ----------------------------------------------------------------------------
`default_nettype none
package pmat_pkg;
  localparam int OFFSET_BITS = 10;
  localparam int PHYS_PAGES  = 1024;
  localparam int MAX_PROCS   = 8;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int PID_W  = 4;
  localparam int SIZE_W = 21;
  localparam int VA_W   = 20;
  localparam int BYTE_W = 8;
  localparam int BRK_W  = 21;

  // derived sizes
  localparam int PPN_W     = $clog2(PHYS_PAGES);
  localparam int PROC_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RAM_AW    = PPN_W + OFFSET_BITS;
  localparam int RAM_DEPTH = 1 << RAM_AW;
  localparam int MAP_AW    = PROC_W + PPN_W;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  localparam int MAP_W     = PPN_W + 1;
  localparam int FREE_W    = $clog2(PHYS_PAGES + 1);
  localparam int PAGES_W   = SIZE_W + 1 - OFFSET_BITS;
  localparam int SUM_W     = SIZE_W + 2;
  localparam longint RAM_BYTES = longint'(PHYS_PAGES) << OFFSET_BITS;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
endpackage
`default_nettype wire

>>> sv/pmat_ram.sv
// ----------------------------------------------------------------------------
// pmat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pmat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/paged_memory_allocator_translator.sv
// ----------------------------------------------------------------------------
// paged_memory_allocator_translator
// Page allocator and virtual-to-physical byte access for several processes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | cmd, process_id, size, va, data
//  out_    | output    | out_valid / out_ready  | status, read_data, alloc_address
//  cfg_    | input     | cfg_we (no wait)       | cfg_initial_break
//
// Read/write: accept, map read, RAM access, result.
// Allocate: check, then scan the owner table one entry at a time (one owner
// port; a read state, then a check state per entry) up to the last page claimed.
// After reset a clearing pass over every RAM address zeroes RAM, owners and maps;
// in_ready stays low meanwhile. A result waits in the output register;
// the next item is taken only once it has been moved there.
// ----------------------------------------------------------------------------
`default_nettype none
module paged_memory_allocator_translator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pmat_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [pmat_pkg::PID_W-1:0]  in_process_id,
  input  wire logic [pmat_pkg::SIZE_W-1:0] in_request_size,
  input  wire logic [pmat_pkg::VA_W-1:0]   in_virtual_address,
  input  wire logic [pmat_pkg::BYTE_W-1:0] in_write_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic      [pmat_pkg::BYTE_W-1:0] out_read_data,
  output logic      [pmat_pkg::BRK_W-1:0]  out_alloc_address,
  input  wire logic                        cfg_we,
  input  wire logic [pmat_pkg::BRK_W-1:0]  cfg_initial_break
);
  localparam int PPN_W   = pmat_pkg::PPN_W;
  localparam int OFF_W   = pmat_pkg::OFFSET_BITS;
  localparam int PROC_W  = pmat_pkg::PROC_W;
  localparam int PAGES_W = pmat_pkg::PAGES_W;
  localparam int SUM_W   = pmat_pkg::SUM_W;
  localparam int BRK_W   = pmat_pkg::BRK_W;
  localparam int FREE_W  = pmat_pkg::FREE_W;
  localparam int RAM_AW  = pmat_pkg::RAM_AW;
  localparam int MAP_AW  = pmat_pkg::MAP_AW;
  localparam int MAP_W   = pmat_pkg::MAP_W;

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ACHK  = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_SCHK  = 4'd4;
  localparam logic [3:0] ST_MRD   = 4'd5;
  localparam logic [3:0] ST_MCHK  = 4'd6;
  localparam logic [3:0] ST_RRD   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]                    state_r, state_nxt;
  logic [RAM_AW-1:0]             clr_r, clr_nxt;
  logic [BRK_W-1:0]              ibrk_r;
  logic [BRK_W-1:0]              brk_r [pmat_pkg::MAX_PROCS];
  logic [pmat_pkg::MAX_PROCS-1:0] has_r;
  logic [FREE_W-1:0]             free_r, free_nxt;

  // latched request
  logic [pmat_pkg::CMD_W-1:0]    cmd_r;
  logic [pmat_pkg::PID_W-1:0]    pid_r;
  logic [PROC_W-1:0]             p_r;
  logic [pmat_pkg::SIZE_W-1:0]   size_r;
  logic [pmat_pkg::VA_W-1:0]     va_r;
  logic [pmat_pkg::BYTE_W-1:0]   wd_r;

  // allocation walk
  logic [PAGES_W-1:0]            pages_r, done_r;
  logic [BRK_W-1:0]              bp_r;
  logic [PPN_W-1:0]              scan_r;

  // pending result and output register
  logic                          res_st_r;
  logic [pmat_pkg::BYTE_W-1:0]   res_rd_r;
  logic [BRK_W-1:0]              res_aa_r;
  logic                          out_valid_r;
  logic                          ost_r;
  logic [pmat_pkg::BYTE_W-1:0]   ord_r;
  logic [BRK_W-1:0]              oaa_r;

  // memory ports
  logic                          own_we, map_we, ram_we;
  logic [PPN_W-1:0]              own_waddr;
  logic [pmat_pkg::PID_W-1:0]    own_wdata, own_rdata;
  logic [MAP_AW-1:0]             map_waddr, map_raddr;
  logic [MAP_W-1:0]              map_wdata, map_rdata;
  logic [RAM_AW-1:0]             ram_waddr, ram_raddr;
  logic [pmat_pkg::BYTE_W-1:0]   ram_wdata, ram_rdata;

  logic                          accept, pid_ok, vp_ok;
  logic [SUM_W-1:0]              need_end;
  logic [BRK_W-1:0]              cur_bp;
  logic [PAGES_W-1:0]            req_pages;
  logic [pmat_pkg::VA_W-1:0]     vpage_full;
  logic [PPN_W-1:0]              vpage, map_vpage;
  logic [PROC_W-1:0]             p_in;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_status        = ost_r;
  assign out_read_data     = ord_r;
  assign out_alloc_address = oaa_r;

  assign pid_ok = (in_process_id != '0) &&
                  (in_process_id <= pmat_pkg::PID_W'(pmat_pkg::MAX_PROCS));
  assign p_in   = PROC_W'(in_process_id - pmat_pkg::PID_W'(1));

  // request decode
  assign cur_bp     = has_r[p_r] ? brk_r[p_r] : ibrk_r;
  assign req_pages  = PAGES_W'((SUM_W'(size_r) + SUM_W'((1 << OFF_W) - 1)) >> OFF_W);
  assign need_end   = SUM_W'(cur_bp) + (SUM_W'(req_pages) << OFF_W);
  assign vpage_full = va_r >> OFF_W;
  assign vp_ok      = vpage_full < pmat_pkg::VA_W'(pmat_pkg::PHYS_PAGES);
  assign vpage      = vpage_full[PPN_W-1:0];
  assign map_vpage  = PPN_W'((bp_r >> OFF_W) + BRK_W'(done_r));

  // memory addressing
  assign map_raddr = {p_r, vpage};
  assign ram_raddr = {map_rdata[PPN_W-1:0], va_r[OFF_W-1:0]};

  always_comb begin
    own_we    = 1'b0;
    own_waddr = scan_r;
    own_wdata = pid_r;
    map_we    = 1'b0;
    map_waddr = {p_r, map_vpage};
    map_wdata = {1'b1, scan_r};
    ram_we    = 1'b0;
    ram_waddr = ram_raddr;
    ram_wdata = wd_r;
    if (state_r == ST_CLEAR) begin
      own_we    = 1'b1;
      own_waddr = clr_r[PPN_W-1:0];
      own_wdata = '0;
      map_we    = 1'b1;
      map_waddr = clr_r[MAP_AW-1:0];
      map_wdata = '0;
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_SCHK && own_rdata == '0) begin
      own_we = 1'b1;
      map_we = 1'b1;
    end else if (state_r == ST_MCHK && cmd_r == pmat_pkg::CMD_WRITE &&
                 map_rdata[MAP_W-1] && vp_ok) begin
      ram_we = 1'b1;
    end
  end

  pmat_ram #(.WIDTH(pmat_pkg::PID_W), .DEPTH(pmat_pkg::PHYS_PAGES)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(scan_r), .rdata(own_rdata)
  );
  pmat_ram #(.WIDTH(MAP_W), .DEPTH(pmat_pkg::MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );
  pmat_ram #(.WIDTH(pmat_pkg::BYTE_W), .DEPTH(pmat_pkg::RAM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    free_nxt  = free_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + RAM_AW'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!pid_ok) begin
            state_nxt = ST_DONE;
          end else if (in_cmd == pmat_pkg::CMD_ALLOC) begin
            state_nxt = ST_ACHK;
          end else if (in_cmd == pmat_pkg::CMD_READ || in_cmd == pmat_pkg::CMD_WRITE) begin
            state_nxt = ST_MRD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ACHK: begin
        if (need_end > SUM_W'(pmat_pkg::RAM_BYTES) ||
            PAGES_W'(free_r) < req_pages || req_pages == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_SRD:  state_nxt = ST_SCHK;
      ST_SCHK: begin
        if (own_rdata == '0) begin
          free_nxt = free_r - FREE_W'(1);
          state_nxt = (done_r + PAGES_W'(1) == pages_r) ? ST_DONE : ST_SRD;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_MRD:  state_nxt = ST_MCHK;
      ST_MCHK: begin
        state_nxt = (cmd_r == pmat_pkg::CMD_READ && map_rdata[MAP_W-1] && vp_ok) ?
                    ST_RRD : ST_DONE;
      end
      ST_RRD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      free_r      <= FREE_W'(pmat_pkg::PHYS_PAGES);
      has_r       <= '0;
      ibrk_r      <= BRK_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
      if (cfg_we) begin
        ibrk_r <= cfg_initial_break;
      end
      if (state_r == ST_ACHK && state_nxt != ST_DONE) begin
        has_r[p_r] <= 1'b1;
      end else if (state_r == ST_ACHK && req_pages == '0 &&
                   need_end <= SUM_W'(pmat_pkg::RAM_BYTES)) begin
        has_r[p_r] <= 1'b1;
      end
      if (state_r == ST_DONE && state_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      pid_r    <= in_process_id;
      p_r      <= p_in;
      size_r   <= in_request_size;
      va_r     <= in_virtual_address;
      wd_r     <= in_write_data;
      res_st_r <= 1'b1;
      res_rd_r <= '0;
      res_aa_r <= '0;
    end
    if (state_r == ST_ACHK) begin
      pages_r <= req_pages;
      bp_r    <= cur_bp;
      done_r  <= '0;
      scan_r  <= '0;
      if (need_end <= SUM_W'(pmat_pkg::RAM_BYTES) && PAGES_W'(free_r) >= req_pages) begin
        res_st_r   <= 1'b0;
        res_aa_r   <= cur_bp;
        brk_r[p_r] <= need_end[BRK_W-1:0];
      end
    end
    if (state_r == ST_SCHK) begin
      scan_r <= scan_r + PPN_W'(1);
      if (own_rdata == '0) begin
        done_r <= done_r + PAGES_W'(1);
      end
    end
    if (state_r == ST_MCHK && map_rdata[MAP_W-1] && vp_ok &&
        cmd_r == pmat_pkg::CMD_WRITE) begin
      res_st_r <= 1'b0;
    end
    if (state_r == ST_RRD) begin
      res_st_r <= 1'b0;
      res_rd_r <= ram_rdata;
    end
    if (state_r == ST_DONE && state_nxt == ST_IDLE) begin
      ost_r <= res_st_r;
      ord_r <= res_rd_r;
      oaa_r <= res_aa_r;
    end
  end

  // checks
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(pmat_pkg::PHYS_PAGES))
    else $error("free page count above page total");
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCHK) |-> (done_r < pages_r))
    else $error("allocation walk claimed too many pages");
endmodule
`default_nettype wire

>>> test/pmat_checker.sv
// ----------------------------------------------------------------------------
// pmat_checker
// Watches the command and result channels of the paged memory allocator,
// keeps its own copy of RAM, page owners, maps and breaks, and compares
// every result transfer against the expected one.
// ----------------------------------------------------------------------------
`default_nettype none
module pmat_checker
  import pmat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [PID_W-1:0]  in_process_id,
  input  wire logic [SIZE_W-1:0] in_request_size,
  input  wire logic [VA_W-1:0]   in_virtual_address,
  input  wire logic [BYTE_W-1:0] in_write_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_status,
  input  wire logic [BYTE_W-1:0] out_read_data,
  input  wire logic [BRK_W-1:0]  out_alloc_address,
  input  wire logic              cfg_we,
  input  wire logic [BRK_W-1:0]  cfg_initial_break,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] read_data;
    logic [BRK_W-1:0]  alloc_address;
  } result_t;

  // shadow state of the block
  logic [BYTE_W-1:0] ram_shadow [int];
  logic [PID_W-1:0]  owner_shadow [PHYS_PAGES];
  logic [MAP_W-1:0]  map_shadow [MAX_PROCS][PHYS_PAGES];
  logic [BRK_W-1:0]  break_shadow [MAX_PROCS];
  bit                allocated [MAX_PROCS];
  logic [BRK_W-1:0]  start_break;
  result_t           expected_results [$];

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             result_count);
    fail_count++;
  endtask

  // allocation: round up, check space and free pages, claim lowest first
  function automatic result_t predict_alloc(int p, int pid, longint size);
    result_t r;
    longint pages, bp, free_pages, done;
    r = '0;
    r.status = 1'b1;
    pages = (size + (1 << OFFSET_BITS) - 1) >> OFFSET_BITS;
    bp = allocated[p] ? break_shadow[p] : start_break;
    free_pages = 0;
    done = 0;
    foreach (owner_shadow[i]) if (owner_shadow[i] == 0) free_pages++;
    if (bp + (pages << OFFSET_BITS) > RAM_BYTES || free_pages < pages) return r;
    for (int i = 0; i < PHYS_PAGES && done < pages; i++) begin
      if (owner_shadow[i] == 0) begin
        longint vp;
        vp = (bp + (done << OFFSET_BITS)) >> OFFSET_BITS;
        owner_shadow[i] = pid[PID_W-1:0];
        if (vp < PHYS_PAGES) map_shadow[p][vp] = {1'b1, i[PPN_W-1:0]};
        done++;
      end
    end
    r.status = 1'b0;
    r.alloc_address = bp[BRK_W-1:0];
    break_shadow[p] = BRK_W'(bp + (pages << OFFSET_BITS));
    allocated[p] = 1'b1;
    return r;
  endfunction

  // one command in, one expected result out
  function automatic result_t predict_command(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                              logic [SIZE_W-1:0] size, logic [VA_W-1:0] va,
                                              logic [BYTE_W-1:0] wd);
    result_t r;
    int p, vp, pa;
    r = '0;
    r.status = 1'b1;
    if (pid < 1 || pid > MAX_PROCS) return r;
    p = pid - 1;
    if (cmd == CMD_ALLOC) return predict_alloc(p, pid, size);
    if (cmd != CMD_READ && cmd != CMD_WRITE) return r;
    vp = va >> OFFSET_BITS;
    if (vp >= PHYS_PAGES || !map_shadow[p][vp][MAP_W-1]) return r;
    pa = (int'(map_shadow[p][vp][PPN_W-1:0]) << OFFSET_BITS) |
         (va & ((1 << OFFSET_BITS) - 1));
    r.status = 1'b0;
    if (cmd == CMD_READ) r.read_data = ram_shadow.exists(pa) ? ram_shadow[pa] : '0;
    else ram_shadow[pa] = wd;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      ram_shadow.delete();
      foreach (owner_shadow[i]) owner_shadow[i] = '0;
      foreach (map_shadow[i, j]) map_shadow[i][j] = '0;
      foreach (allocated[i]) begin
        allocated[i] = 1'b0;
        break_shadow[i] = '0;
      end
      start_break = BRK_W'(1024);
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) start_break = cfg_initial_break;
      if (in_valid && in_ready)
        expected_results.push_back(predict_command(in_cmd, in_process_id, in_request_size,
                                                   in_virtual_address, in_write_data));
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report("result transfers beyond commands", result_count, result_count - 1);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_read_data !== want.read_data)
            report("read_data", out_read_data, want.read_data);
          if (out_alloc_address !== want.alloc_address)
            report("alloc_address", out_alloc_address, want.alloc_address);
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule
`default_nettype wire

>>> test/tb_paged_memory_allocator_translator.sv
// ----------------------------------------------------------------------------
// tb_paged_memory_allocator_translator
// Drives allocate, read and write commands from several processes under
// bursty input and stalling output, changes the starting break between
// phases, and leaves result checking to pmat_checker.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_paged_memory_allocator_translator;
  import pmat_pkg::*;

  // command code the block does not know
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [PID_W-1:0]  in_process_id = '0;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [VA_W-1:0]   in_virtual_address = '0;
  logic [BYTE_W-1:0] in_write_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_status;
  logic [BYTE_W-1:0] out_read_data;
  logic [BRK_W-1:0]  out_alloc_address;
  logic              cfg_we = 1'b0;
  logic [BRK_W-1:0]  cfg_initial_break = '0;
  int                fail_count, pending_count, result_count;
  int                sent_count = 0;
  bit                hold_off = 1'b0;
  // access window per process, opened on any accepted alloc under 4096 bytes
  int                region_base [MAX_PROCS + 1];
  int                region_top [MAX_PROCS + 1];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  paged_memory_allocator_translator DUT (.*);

  pmat_checker u_checker (.*);

  // receiver: own stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else case (sent_count / 150 % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(3) != 0);
      default: out_ready <= ($urandom_range(2) == 0);
    endcase
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input int pid, input int size,
                      input int va, input int wd);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_process_id <= PID_W'(pid);
    in_request_size <= SIZE_W'(size);
    in_virtual_address <= VA_W'(va);
    in_write_data <= BYTE_W'(wd);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(6, 1)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_break(input int value);
    cfg_we <= 1'b1;
    cfg_initial_break <= BRK_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random item: mostly accesses inside the process's window, some allocs, some noise
  task automatic random_item();
    int pid, sel, va;
    pid = $urandom_range(MAX_PROCS, 1);
    sel = $urandom_range(99);
    if (region_top[pid] > region_base[pid])
      va = $urandom_range(region_top[pid] - 1, region_base[pid]) & 20'hFFFFF;
    else va = $urandom_range(20'hFFFFF);
    if (sel < 12) send(CMD_ALLOC, pid, $urandom_range(3000), 0, 0);
    else if (sel < 14) send(CMD_ALLOC, pid, $urandom_range(21'h1FFFFF), 0, 0);
    else if (sel < 50) send(CMD_WRITE, pid, $urandom, va, $urandom);
    else if (sel < 88) send(CMD_READ, pid, $urandom, va, $urandom);
    else send(CMD_W'($urandom_range(3)), $urandom_range(15), $urandom, $urandom, $urandom);
  endtask

  // open a process's access window on any accepted alloc under 4096 bytes
  always @(posedge clk) begin
    if (in_valid && in_ready && in_cmd == CMD_ALLOC && in_process_id >= 1 &&
        in_process_id <= MAX_PROCS && in_request_size < 4096) begin
      region_base[in_process_id] <= 0;
      region_top[in_process_id] <= 1 << 19;
    end
  end

  initial begin
    #200_000_000;
    $display("FAIL paged_memory_allocator_translator");
    $finish;
  end

  initial begin
    foreach (region_top[i]) begin
      region_base[i] = 0;
      region_top[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, bad process, unknown command
    send(CMD_ALLOC, 1, 0, 0, 0);
    send(CMD_ALLOC, 1, 1, 0, 0);
    send(CMD_WRITE, 1, 0, 1024, 8'hFF);
    send(CMD_READ, 1, 0, 1024, 0);
    send(CMD_READ, 1, 0, 2047, 0);
    send(CMD_WRITE, 1, 0, 2048, 8'h55);
    send(CMD_ALLOC, 2, 2000, 0, 0);
    send(CMD_WRITE, 2, 0, 2047, 8'hAA);
    send(CMD_READ, 2, 0, 2047, 0);
    send(CMD_READ, 2, 0, 20'hFFFFF, 0);
    send(CMD_ALLOC, 0, 5, 0, 0);
    send(CMD_READ, 9, 0, 1024, 0);
    send(CMD_WRITE, 15, 0, 1024, 1);
    send(CMD_UNKNOWN, 1, 21'h1FFFFF, 20'hFFFFF, 8'hFF);
    send(CMD_ALLOC, 3, 21'h1FFFFF, 0, 0);
    send(CMD_ALLOC, 3, 1 << 20, 0, 0);
    send(CMD_ALLOC, MAX_PROCS, 1500, 0, 0);
    send(CMD_WRITE, MAX_PROCS, 0, 1024 + 700, 8'h3C);
    send(CMD_READ, MAX_PROCS, 0, 1024 + 700, 0);
    drain();

    // unaligned break, then break at the RAM size, then zero
    set_break(1500);
    send(CMD_ALLOC, 4, 100, 0, 0);
    send(CMD_WRITE, 4, 0, 1500, 8'h11);
    send(CMD_READ, 4, 0, 2600, 0);
    drain();
    set_break(1 << 20);
    send(CMD_ALLOC, 5, 0, 0, 0);
    send(CMD_ALLOC, 5, 1, 0, 0);
    drain();
    set_break(0);
    send(CMD_ALLOC, 6, 4096, 0, 0);
    send(CMD_WRITE, 6, 0, 10, 8'h77);
    send(CMD_READ, 6, 0, 10, 0);
    drain();
    set_break($urandom_range(20000));

    // random bursts; long receiver hold-off while input keeps coming
    for (int n = 0; n < 750; n++) begin
      if (n == 200) fork
        begin
          hold_off = 1'b1;
          repeat (400) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      if (n == 400) begin
        drain();
        set_break(21'h0FFC00);
      end
      if (n == 600) begin
        drain();
        set_break(0);
      end
      random_item();
      if ($urandom_range(7) == 0) gap();
    end
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d commands, %0d results, allocs/reads/writes with break changes",
             sent_count, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("PASS paged_memory_allocator_translator");
    else
      $display("FAIL paged_memory_allocator_translator");
    $finish;
  end

endmodule
`default_nettype wire
